@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros: shared assertion shorthands
// clocked implication checks with an active-low asynchronous reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/i2a_pkg.sv @@
// ---------------------------------------------------------------------------
// i2a_pkg: shared definitions of the integer to ascii formatter
// widths, character codes, cell controls and the sequencer states
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int TDATA_W     = 64;
	// decimal digits of a VALUE_WIDTH-bit unsigned value (log10(2) ~ 1233/4096)
	localparam int DEC_DIGITS  = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int HEX_DIGITS  = (VALUE_WIDTH + 3) / 4;
	localparam int NUM_CELLS   = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_CNT_W   = $clog2(NUM_CELLS + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X     = 8'h78;

	localparam logic OP_DEC = 1'b0;
	localparam logic OP_HEX = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_BIT,
		CELL_DIGIT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     dec;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_PFX0,
		ST_PFXX,
		ST_EMIT
	} state_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return CH_ZERO + {4'b0000, d};
		end else begin
			return CH_A + {4'b0000, d} - 8'd10;
		end
	endfunction

endpackage

`default_nettype wire

@@ rtl/i2a_cell.sv @@
// ---------------------------------------------------------------------------
// i2a_cell: one digit cell of the conversion chain
// double-dabble digit with bit shift, digit shift and clear
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2a_cell (
	input  wire                     clk,
	input  wire i2a_pkg::cell_ctl_t ctl,
	input  wire                     bit_in,
	input  wire  [3:0]              dig_in,
	output logic                    carry_out,
	output logic [3:0]              dig
);

	logic [3:0] digit_q;
	logic [3:0] corr;

	// in decimal mode, add three before the shift when the digit would pass nine
	assign corr      = (ctl.dec && digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = corr[3];
	assign dig       = digit_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			i2a_pkg::CELL_CLEAR: digit_q <= 4'd0;
			i2a_pkg::CELL_BIT:   digit_q <= {corr[2:0], bit_in};
			i2a_pkg::CELL_DIGIT: digit_q <= dig_in;
			default:             digit_q <= digit_q;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/integer_to_ascii_formatter.sv @@
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter: 64-bit integer to decimal or hex ascii text
// one input item in, one output item per character, last character flagged
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one item: value in tdata, op in tuser (0 signed decimal,
//   1 unsigned hex with a 0x prefix). m_axis returns the text one character
//   per item, most significant first, with tlast on the final character.
//   an item is taken only while the block is idle; it then shifts the value
//   bit by bit into a row of digit cells, one bit per cycle through the
//   whole row (double dabble in decimal, plain nibble shift in hex). after
//   that the sign or prefix goes out, and the cells shift one digit per
//   cycle toward the top cell, leading zeros skipped; a shown digit waits
//   while the output register still holds a character not yet taken.
//   the output register holds a character while m_axis_tready is low and
//   the sequencer waits; no character is dropped.
//   reset clears the sequencer and the output valid; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [63:0] s_axis_tdata,   // [63:0] value
	input  wire         s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] character
	output logic        m_axis_tlast    // last
);

	localparam int W = i2a_pkg::VALUE_WIDTH;
	localparam int N = i2a_pkg::NUM_CELLS;

	i2a_pkg::state_t    state_q, state_d;
	i2a_pkg::cell_ctl_t ctl;

	logic                          dec_q;
	logic                          neg_q;
	logic                          started_q;
	logic [W-1:0]                  mag_q;
	logic [i2a_pkg::BIT_CNT_W-1:0] bcnt_q;
	logic [i2a_pkg::DIG_CNT_W-1:0] dcnt_q;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_last_q;

	// sequencer outputs
	logic       s_acc;
	logic       out_free;
	logic       load_out;
	logic [7:0] char_d;
	logic       last_d;
	logic       dig_step;
	logic       mark_start;

	// value seen on the input
	logic [W-1:0] in_val;
	logic         in_neg;

	// chain wiring
	logic       carry [N];
	logic [3:0] dig   [N];
	logic [3:0] top_dig;
	logic       last_dig;

	assign in_val   = s_axis_tdata[W-1:0];
	assign in_neg   = (s_axis_tuser == i2a_pkg::OP_DEC) && in_val[W-1];
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign top_dig  = dig[N-1];
	assign last_dig = (dcnt_q == i2a_pkg::DIG_CNT_W'(1));

	// row of digit cells, value msb enters at cell 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic       b_in;
		logic [3:0] d_in;
		if (i == 0) begin : g_first
			assign b_in = mag_q[W-1];
			assign d_in = 4'd0;
		end else begin : g_rest
			assign b_in = carry[i-1];
			assign d_in = dig[i-1];
		end
		i2a_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.bit_in    (b_in),
			.dig_in    (d_in),
			.carry_out (carry[i]),
			.dig       (dig[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		ctl.op        = i2a_pkg::CELL_HOLD;
		ctl.dec       = dec_q;
		s_axis_tready = 1'b0;
		load_out      = 1'b0;
		char_d        = i2a_pkg::CH_ZERO;
		last_d        = 1'b0;
		dig_step      = 1'b0;
		mark_start    = 1'b0;
		case (state_q)
			i2a_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					ctl.op  = i2a_pkg::CELL_CLEAR;
					state_d = i2a_pkg::ST_CONV;
				end
			end
			i2a_pkg::ST_CONV: begin
				ctl.op = i2a_pkg::CELL_BIT;
				if (bcnt_q == i2a_pkg::BIT_CNT_W'(1)) begin
					if (!dec_q) begin
						state_d = i2a_pkg::ST_PFX0;
					end else if (neg_q) begin
						state_d = i2a_pkg::ST_SIGN;
					end else begin
						state_d = i2a_pkg::ST_EMIT;
					end
				end
			end
			i2a_pkg::ST_SIGN: begin
				if (out_free) begin
					load_out = 1'b1;
					char_d   = i2a_pkg::CH_MINUS;
					state_d  = i2a_pkg::ST_EMIT;
				end
			end
			i2a_pkg::ST_PFX0: begin
				if (out_free) begin
					load_out = 1'b1;
					char_d   = i2a_pkg::CH_ZERO;
					state_d  = i2a_pkg::ST_PFXX;
				end
			end
			i2a_pkg::ST_PFXX: begin
				if (out_free) begin
					load_out = 1'b1;
					char_d   = i2a_pkg::CH_X;
					state_d  = i2a_pkg::ST_EMIT;
				end
			end
			i2a_pkg::ST_EMIT: begin
				if (!started_q && top_dig == 4'd0 && !last_dig) begin
					// leading zero, drop it
					ctl.op   = i2a_pkg::CELL_DIGIT;
					dig_step = 1'b1;
				end else if (out_free) begin
					ctl.op     = i2a_pkg::CELL_DIGIT;
					dig_step   = 1'b1;
					mark_start = 1'b1;
					load_out   = 1'b1;
					char_d     = i2a_pkg::digit_char(top_dig);
					last_d     = last_dig;
					if (last_dig) begin
						state_d = i2a_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = i2a_pkg::ST_IDLE;
			end
		endcase
	end

	// item context, value shifter and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q     <= 1'b1;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			bcnt_q    <= '0;
			dcnt_q    <= '0;
		end else begin
			if (s_acc) begin
				dec_q     <= (s_axis_tuser == i2a_pkg::OP_DEC);
				neg_q     <= in_neg;
				started_q <= 1'b0;
				bcnt_q    <= i2a_pkg::BIT_CNT_W'(W);
				dcnt_q    <= i2a_pkg::DIG_CNT_W'(N);
			end else begin
				if (ctl.op == i2a_pkg::CELL_BIT) begin
					bcnt_q <= bcnt_q - 1'b1;
				end
				if (dig_step) begin
					dcnt_q <= dcnt_q - 1'b1;
				end
				if (mark_start) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	// magnitude, formed unsigned so the most negative value converts cleanly
	always_ff @(posedge clk) begin
		if (s_acc) begin
			mag_q <= in_neg ? (~in_val + 1'b1) : in_val;
		end else if (ctl.op == i2a_pkg::CELL_BIT) begin
			mag_q <= {mag_q[W-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

@@ rtl/i2a_checker.sv @@
// ---------------------------------------------------------------------------
// i2a_checker: port-level checks of the integer to ascii formatter
// bound to the top level, watches both streams
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module i2a_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast
);

	logic s_acc;
	logic is_digit;
	logic is_hex_letter;
	logic is_mark;

	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign is_digit      = (m_axis_tdata >= i2a_pkg::CH_ZERO) && (m_axis_tdata <= i2a_pkg::CH_NINE);
	assign is_hex_letter = (m_axis_tdata >= i2a_pkg::CH_A) && (m_axis_tdata <= i2a_pkg::CH_F);
	assign is_mark       = (m_axis_tdata == i2a_pkg::CH_MINUS) || (m_axis_tdata == i2a_pkg::CH_X);

	// one item at a time: busy right after taking one
	`ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_acc, !s_axis_tready)

	// stalled character holds
	`ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// only digits, lowercase hex letters, sign or prefix letter go out
	`ASSERT_IMP(a_char_set, clk, arst_n, m_axis_tvalid, is_digit || is_hex_letter || is_mark)

	// sign and prefix letter never end the text
	`ASSERT_IMP(a_mark_not_last, clk, arst_n, m_axis_tvalid && is_mark, !m_axis_tlast)

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
